### hdl/mi3_pkg.sv
`timescale 1ns / 1ps

package mi3_pkg;

  // element format
  localparam int WORD_BITS = 32;
  localparam int FRAC_BITS = 16;
  localparam int THR_BITS  = 17;
  localparam int ELEMS     = 9;

  // exact intermediate widths
  localparam int PROD_W = 2 * WORD_BITS;
  localparam int COF_W  = 2 * WORD_BITS + 1;
  localparam int PART_W = 2 * WORD_BITS + 1;
  localparam int DET_W  = 3 * WORD_BITS + 1;
  localparam int DMAG_W = 3 * WORD_BITS;
  localparam int CMAG_W = 2 * WORD_BITS;

  // rounding numerator and divider widths
  localparam int SHIFT  = 2 * FRAC_BITS + 1;
  localparam int NUM_A  = CMAG_W + SHIFT;
  localparam int NUM_W  = ((NUM_A > DMAG_W) ? NUM_A : DMAG_W) + 1;
  localparam int DEN_W  = DMAG_W + 1;
  localparam int REM_W  = DEN_W + 1;
  localparam int CMP_A  = DEN_W + WORD_BITS;
  localparam int CMP_W  = (CMP_A > NUM_W) ? CMP_A : NUM_W;

  typedef logic signed [WORD_BITS-1:0] word_t;

  // one element in flight through the divider
  typedef struct packed {
    logic [REM_W-1:0]     rem;
    logic [WORD_BITS-1:0] bits;
  } lane_t;

  // one item in flight through the divider
  typedef struct packed {
    logic [DEN_W-1:0]         den;
    logic [ELEMS-1:0]         neg;
    logic [ELEMS-1:0]         big;
    logic                     singular;
    lane_t [ELEMS-1:0]        lane;
  } div_t;

endpackage

### hdl/matrix_inverse_3x3_core.sv
`timescale 1ns / 1ps

// 3x3 matrix inverse by the adjugate, signed Q16.16 in and out. One matrix is
// taken every cycle unless a result waits at the output; each item passes
// through 5 stages of cofactors and determinant, 2 stages of magnitude and
// range checks, 32 stages of a restoring divider that settles one quotient
// bit per stage for all nine elements at once, and the output register. The
// whole pipeline holds while a result waits at the output. Elements are
// rounded to nearest with ties away from zero and saturate with overflow
// raised; a determinant whose magnitude is at or below zero_threshold (written
// through the cfg port, reset 1) gives the zero matrix with singular raised.

module matrix_inverse_3x3_core (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [mi3_pkg::WORD_BITS-1:0]    m00,
  input  logic [mi3_pkg::WORD_BITS-1:0]    m01,
  input  logic [mi3_pkg::WORD_BITS-1:0]    m02,
  input  logic [mi3_pkg::WORD_BITS-1:0]    m10,
  input  logic [mi3_pkg::WORD_BITS-1:0]    m11,
  input  logic [mi3_pkg::WORD_BITS-1:0]    m12,
  input  logic [mi3_pkg::WORD_BITS-1:0]    m20,
  input  logic [mi3_pkg::WORD_BITS-1:0]    m21,
  input  logic [mi3_pkg::WORD_BITS-1:0]    m22,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [mi3_pkg::WORD_BITS-1:0]    r00,
  output logic [mi3_pkg::WORD_BITS-1:0]    r01,
  output logic [mi3_pkg::WORD_BITS-1:0]    r02,
  output logic [mi3_pkg::WORD_BITS-1:0]    r10,
  output logic [mi3_pkg::WORD_BITS-1:0]    r11,
  output logic [mi3_pkg::WORD_BITS-1:0]    r12,
  output logic [mi3_pkg::WORD_BITS-1:0]    r20,
  output logic [mi3_pkg::WORD_BITS-1:0]    r21,
  output logic [mi3_pkg::WORD_BITS-1:0]    r22,
  output logic                             singular,
  output logic                             overflow,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [mi3_pkg::THR_BITS-1:0]     cfg_data
);

  localparam int W = mi3_pkg::WORD_BITS;

  logic                                  en;
  logic [mi3_pkg::THR_BITS-1:0]          zero_threshold;
  mi3_pkg::word_t [8:0]                  m;
  logic                                  det_valid;
  logic [mi3_pkg::DET_W-1:0]             det;
  logic [8:0][mi3_pkg::COF_W-1:0]        cof;

  logic                                  v6;
  logic [mi3_pkg::DMAG_W-1:0]            dmag6;
  logic                                  dneg6;
  logic [8:0][mi3_pkg::CMAG_W-1:0]       cmag6;
  logic [8:0]                            cneg6;
  logic [mi3_pkg::DET_W-1:0]             dabs;
  logic [mi3_pkg::COF_W-1:0]             cabs [9];

  mi3_pkg::div_t                         st7_next;
  mi3_pkg::div_t                         st7;
  logic                                  v7;
  logic [mi3_pkg::NUM_W-1:0]             num;
  logic [mi3_pkg::DMAG_W-1:0]            lim;

  mi3_pkg::div_t                         dst [W+1];
  logic [W:0]                            dv;

  logic [8:0][W-1:0]                     res;
  logic [8:0][W-1:0]                     res_next;
  logic                                  ovf_next;
  logic [W-1:0]                          limit;
  logic [W-1:0]                          mag;
  logic                                  sat;

  // the whole pipeline moves unless a result is held at the output
  assign en        = !out_valid || out_ready;
  assign in_ready  = en;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      zero_threshold <= mi3_pkg::THR_BITS'(1);
    end else if (cfg_valid) begin
      zero_threshold <= cfg_data;
    end
  end

  assign m = {m22, m21, m20, m12, m11, m10, m02, m01, m00};

  mi3_det u_det (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (in_valid),
    .m        (m),
    .valid    (det_valid),
    .det      (det),
    .cof      (cof)
  );

  // stage 6: magnitudes and signs
  always_comb begin
    dabs = det[mi3_pkg::DET_W-1] ? (~det + 1'b1) : det;
    for (int k = 0; k < 9; k++) begin
      cabs[k] = cof[k][mi3_pkg::COF_W-1] ? (~cof[k] + 1'b1) : cof[k];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
    end else if (en) begin
      v6 <= det_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dmag6 <= dabs[mi3_pkg::DMAG_W-1:0];
      dneg6 <= det[mi3_pkg::DET_W-1];
      for (int k = 0; k < 9; k++) begin
        cmag6[k] <= cabs[k][mi3_pkg::CMAG_W-1:0];
        cneg6[k] <= cof[k][mi3_pkg::COF_W-1];
      end
    end
  end

  // stage 7: singular test, rounding numerator, range check, divider load
  always_comb begin
    lim = mi3_pkg::DMAG_W'(zero_threshold) << (2 * mi3_pkg::FRAC_BITS);
    st7_next          = '0;
    st7_next.den      = {dmag6, 1'b0};
    st7_next.singular = (dmag6 <= lim);
    num               = '0;
    for (int k = 0; k < 9; k++) begin
      // output element k takes the transposed cofactor
      num = (mi3_pkg::NUM_W'(cmag6[(k % 3) * 3 + k / 3]) << mi3_pkg::SHIFT)
          + mi3_pkg::NUM_W'(dmag6);
      st7_next.neg[k] = cneg6[(k % 3) * 3 + k / 3] ^ dneg6;
      st7_next.big[k] = (mi3_pkg::CMP_W'(num)
                         >= (mi3_pkg::CMP_W'(st7_next.den) << W));
      st7_next.lane[k].rem  = mi3_pkg::REM_W'(num >> W);
      st7_next.lane[k].bits = num[W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v7 <= 1'b0;
    end else if (en) begin
      v7 <= v6;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st7 <= st7_next;
    end
  end

  assign dv[0]  = v7;
  assign dst[0] = st7;

  // divider: one quotient bit per stage
  for (genvar s = 0; s < W; s++) begin : g_div
    mi3_div_step u_step (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .in_valid (dv[s]),
      .d_in     (dst[s]),
      .valid    (dv[s+1]),
      .d_out    (dst[s+1])
    );
  end

  // rounding is done, apply sign and saturation
  always_comb begin
    res_next = '0;
    ovf_next = 1'b0;
    limit    = '0;
    mag      = '0;
    sat      = 1'b0;
    for (int k = 0; k < 9; k++) begin
      limit = {1'b0, {(W-1){1'b1}}} + W'(dst[W].neg[k]);
      sat   = dst[W].big[k] || (dst[W].lane[k].bits > limit);
      mag   = sat ? limit : dst[W].lane[k].bits;
      if (!dst[W].singular) begin
        res_next[k] = dst[W].neg[k] ? (~mag + 1'b1) : mag;
        ovf_next    = ovf_next | sat;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= dv[W];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res      <= res_next;
      singular <= dst[W].singular;
      overflow <= ovf_next;
    end
  end

  assign r00 = res[0];
  assign r01 = res[1];
  assign r02 = res[2];
  assign r10 = res[3];
  assign r11 = res[4];
  assign r12 = res[5];
  assign r20 = res[6];
  assign r21 = res[7];
  assign r22 = res[8];

endmodule

### hdl/mi3_det.sv
`timescale 1ns / 1ps

module mi3_det (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      en,
  input  logic                                      in_valid,
  input  mi3_pkg::word_t [8:0]                      m,
  output logic                                      valid,
  output logic [mi3_pkg::DET_W-1:0]                 det,
  output logic [8:0][mi3_pkg::COF_W-1:0]            cof
);

  localparam int W = mi3_pkg::WORD_BITS;

  logic [8:0][mi3_pkg::PROD_W-1:0]  prod_p;
  logic [8:0][mi3_pkg::PROD_W-1:0]  prod_q;
  mi3_pkg::word_t [2:0]             row0_s1;
  mi3_pkg::word_t [2:0]             row0_s2;
  logic [8:0][mi3_pkg::COF_W-1:0]   cof_s2;
  logic [8:0][mi3_pkg::COF_W-1:0]   cof_s3;
  logic [8:0][mi3_pkg::COF_W-1:0]   cof_s4;
  logic [8:0][mi3_pkg::COF_W-1:0]   cof_s5;
  logic [2:0][mi3_pkg::PART_W-1:0]  lo_s3;
  logic [2:0][mi3_pkg::PART_W-1:0]  hi_s3;
  logic [2:0][mi3_pkg::DET_W-1:0]   term_s4;
  logic [mi3_pkg::DET_W-1:0]        det_s5;
  logic [4:0]                       vld;

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[3:0], in_valid};
    end
  end

  // stage 1: the two minor products of every cofactor
  for (genvar i = 0; i < 3; i++) begin : g_row
    for (genvar j = 0; j < 3; j++) begin : g_col
      localparam int I1 = (i + 1) % 3;
      localparam int I2 = (i + 2) % 3;
      localparam int J1 = (j + 1) % 3;
      localparam int J2 = (j + 2) % 3;
      always_ff @(posedge clk) begin
        if (en) begin
          prod_p[i*3+j] <= $signed(m[I1*3+J1]) * $signed(m[I2*3+J2]);
          prod_q[i*3+j] <= $signed(m[I1*3+J2]) * $signed(m[I2*3+J1]);
        end
      end
    end
  end

  // stage 2: cofactors, stage 3: split products for the determinant
  always_ff @(posedge clk) begin
    if (en) begin
      row0_s1 <= m[2:0];
      row0_s2 <= row0_s1;
      for (int k = 0; k < 9; k++) begin
        cof_s2[k] <= $signed({prod_p[k][mi3_pkg::PROD_W-1], prod_p[k]})
                   - $signed({prod_q[k][mi3_pkg::PROD_W-1], prod_q[k]});
      end
      for (int j = 0; j < 3; j++) begin
        lo_s3[j] <= $signed({1'b0, cof_s2[j][W-1:0]}) * $signed(row0_s2[j]);
        hi_s3[j] <= $signed(cof_s2[j][mi3_pkg::COF_W-1:W]) * $signed(row0_s2[j]);
      end
      cof_s3 <= cof_s2;
    end
  end

  // stage 4: rejoin the partial products, stage 5: sum along row 0
  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        term_s4[j] <= {hi_s3[j], {W{1'b0}}}
                    + {{(mi3_pkg::DET_W-mi3_pkg::PART_W){lo_s3[j][mi3_pkg::PART_W-1]}},
                       lo_s3[j]};
      end
      cof_s4 <= cof_s3;
      det_s5 <= term_s4[0] + term_s4[1] + term_s4[2];
      cof_s5 <= cof_s4;
    end
  end

  assign valid = vld[4];
  assign det   = det_s5;
  assign cof   = cof_s5;

endmodule

### hdl/mi3_div_step.sv
`timescale 1ns / 1ps

module mi3_div_step (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  mi3_pkg::div_t d_in,
  output logic          valid,
  output mi3_pkg::div_t d_out
);

  localparam int W = mi3_pkg::WORD_BITS;

  mi3_pkg::div_t           d_next;
  logic [mi3_pkg::REM_W-1:0] sh;
  logic                    qb;

  // one restoring step per lane: bring down a numerator bit, try the subtract
  always_comb begin
    d_next = d_in;
    sh     = '0;
    qb     = 1'b0;
    for (int k = 0; k < mi3_pkg::ELEMS; k++) begin
      sh = {d_in.lane[k].rem[mi3_pkg::REM_W-2:0], d_in.lane[k].bits[W-1]};
      qb = (sh >= {1'b0, d_in.den});
      d_next.lane[k].rem  = qb ? (sh - {1'b0, d_in.den}) : sh;
      d_next.lane[k].bits = {d_in.lane[k].bits[W-2:0], qb};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_out <= d_next;
    end
  end

endmodule

### verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  localparam int LATENCY   = 40;
  localparam int N_RANDOM  = 1700;
  localparam int MAX_CYC   = 400000;

  typedef logic [mi3_pkg::WORD_BITS-1:0] elem_t;

  // one matrix and its inverse
  typedef struct {
    elem_t m [9];
  } matrix_t;

  typedef struct {
    elem_t r [9];
    logic  sing;
    logic  ovf;
  } inverse_t;

  // directed row: matrix plus optional hand-typed inverse
  typedef struct {
    matrix_t  mat;
    logic     typed;
    inverse_t inv;
  } vec_row_t;

  logic clk, rst;
  logic in_valid, in_ready, out_valid, out_ready;
  logic cfg_valid, cfg_ready;
  logic [mi3_pkg::THR_BITS-1:0] cfg_data;
  elem_t mi [9];
  elem_t ro [9];
  logic  sing_o, ovf_o;

  logic [mi3_pkg::THR_BITS-1:0] thr_model;
  inverse_t expected_inv [$];
  int  fail_count;
  int  mismatch_count;
  longint cycle_count;
  bit  hold_off_rx;
  bit  drain_done;

  matrix_inverse_3x3_core uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .m00(mi[0]), .m01(mi[1]), .m02(mi[2]),
    .m10(mi[3]), .m11(mi[4]), .m12(mi[5]),
    .m20(mi[6]), .m21(mi[7]), .m22(mi[8]),
    .out_valid(out_valid), .out_ready(out_ready),
    .r00(ro[0]), .r01(ro[1]), .r02(ro[2]),
    .r10(ro[3]), .r11(ro[4]), .r12(ro[5]),
    .r20(ro[6]), .r21(ro[7]), .r22(ro[8]),
    .singular(sing_o), .overflow(ovf_o),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // exact adjugate inverse with round-half-away and saturation
  function automatic inverse_t invert(matrix_t a, logic [mi3_pkg::THR_BITS-1:0] thr);
    inverse_t res;
    logic signed [63:0]  e [9];
    logic signed [130:0] cof [9];
    logic signed [130:0] det;
    logic [130:0] dmag, cmag, lim;
    logic [260:0] num, quo;
    logic neg;
    int i1, i2, j1, j2;
    for (int k = 0; k < 9; k++) e[k] = $signed(a.m[k]);
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) begin
        i1 = (i + 1) % 3; i2 = (i + 2) % 3;
        j1 = (j + 1) % 3; j2 = (j + 2) % 3;
        cof[i*3+j] = 131'(e[i1*3+j1]) * 131'(e[i2*3+j2])
                   - 131'(e[i1*3+j2]) * 131'(e[i2*3+j1]);
      end
    det = 131'(e[0]) * cof[0] + 131'(e[1]) * cof[1] + 131'(e[2]) * cof[2];
    dmag = det[130] ? -det : det;
    lim = 131'(thr) << (2 * mi3_pkg::FRAC_BITS);
    res.ovf = 1'b0;
    res.sing = 1'b0;
    if (dmag <= lim) begin
      for (int k = 0; k < 9; k++) res.r[k] = '0;
      res.sing = 1'b1;
      return res;
    end
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) begin
        cmag = cof[j*3+i][130] ? -cof[j*3+i] : cof[j*3+i];
        neg = cof[j*3+i][130] ^ det[130];
        num = (261'(cmag) << (2 * mi3_pkg::FRAC_BITS + 1)) + 261'(dmag);
        quo = num / (261'(dmag) << 1);
        if (!neg && quo > 261'(32'h7fff_ffff)) begin
          quo = 261'(32'h7fff_ffff); res.ovf = 1'b1;
        end else if (neg && quo > 261'(32'h8000_0000)) begin
          quo = 261'(32'h8000_0000); res.ovf = 1'b1;
        end
        res.r[i*3+j] = neg ? elem_t'(-quo[31:0]) : quo[31:0];
      end
    return res;
  endfunction

  function automatic matrix_t rand_matrix(int mode);
    matrix_t a;
    for (int k = 0; k < 9; k++)
      case (mode)
        0: a.m[k] = $urandom;
        1: a.m[k] = elem_t'($signed($urandom_range(0, 8 << 16)) - (4 << 16));
        2: a.m[k] = elem_t'($signed($urandom_range(0, 512)) - 256);
        default: a.m[k] = ($urandom_range(0, 3) == 0) ? 32'h8000_0000 : $urandom;
      endcase
    // diagonal boost so scaled matrices mostly invert
    if (mode == 1 && $urandom_range(0, 1)) begin
      a.m[0] = elem_t'($signed(a.m[0]) + 32'sd655360);
      a.m[4] = elem_t'($signed(a.m[4]) + 32'sd655360);
      a.m[8] = elem_t'($signed(a.m[8]) + 32'sd655360);
    end
    // rows made dependent for near-singular cases
    if (mode == 1 && $urandom_range(0, 7) == 0)
      for (int c = 0; c < 3; c++) a.m[6+c] = a.m[c];
    return a;
  endfunction

  task automatic write_threshold(logic [mi3_pkg::THR_BITS-1:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    thr_model = v;
  endtask

  // wait for the pipeline to empty
  task automatic drain_results();
    in_valid <= 1'b0;
    while (expected_inv.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic send_matrix(matrix_t a, logic typed, inverse_t inv);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 16) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    for (int k = 0; k < 9; k++) mi[k] <= a.m[k];
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    expected_inv.push_back(typed ? inv : invert(a, thr_model));
  endtask

  // stimulus
  initial begin
    vec_row_t rows [$];
    vec_row_t row;
    inverse_t zero_inv, none;
    matrix_t a;
    int pick;
    rst = 1'b1; in_valid = 1'b0; cfg_valid = 1'b0; cfg_data = '0;
    for (int k = 0; k < 9; k++) mi[k] = '0;
    thr_model = 17'd1;
    drain_done = 1'b0;
    hold_off_rx = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int k = 0; k < 9; k++) zero_inv.r[k] = '0;
    zero_inv.sing = 1'b1; zero_inv.ovf = 1'b0;
    none = zero_inv;

    // zero matrix: singular
    for (int k = 0; k < 9; k++) row.mat.m[k] = '0;
    row.typed = 1'b1; row.inv = zero_inv; rows.push_back(row);
    // identity
    for (int k = 0; k < 9; k++) row.mat.m[k] = (k % 4 == 0) ? 32'h0001_0000 : '0;
    row.typed = 1'b1;
    row.inv.r = row.mat.m; row.inv.sing = 1'b0; row.inv.ovf = 1'b0;
    rows.push_back(row);
    // all most negative: singular
    for (int k = 0; k < 9; k++) row.mat.m[k] = 32'h8000_0000;
    row.typed = 1'b1; row.inv = zero_inv; rows.push_back(row);
    // all max
    for (int k = 0; k < 9; k++) row.mat.m[k] = 32'h7fff_ffff;
    row.typed = 1'b0; rows.push_back(row);
    // diagonal extremes, tiny diagonal (singular), negative identity, halves
    for (int v = 0; v < 8; v++) begin
      for (int k = 0; k < 9; k++) row.mat.m[k] = '0;
      case (v)
        0: begin row.mat.m[0] = 32'h8000_0000; row.mat.m[4] = 32'h7fff_ffff;
                 row.mat.m[8] = 32'h0001_0000; end
        1: begin row.mat.m[0] = 32'h0000_0100; row.mat.m[4] = 32'h0000_0100;
                 row.mat.m[8] = 32'h0000_0100; end
        2: begin row.mat.m[0] = 32'hffff_0000; row.mat.m[4] = 32'hffff_0000;
                 row.mat.m[8] = 32'hffff_0000; end
        3: begin row.mat.m[0] = 32'h0000_8000; row.mat.m[4] = 32'h0003_0000;
                 row.mat.m[8] = 32'hfff9_0000; end
        4: begin row.mat.m[2] = 32'h0002_0000; row.mat.m[4] = 32'h0005_0000;
                 row.mat.m[6] = 32'hfffd_0000; end
        5: begin row.mat.m[0] = 32'h0000_0001; row.mat.m[4] = 32'h0000_0001;
                 row.mat.m[8] = 32'h0000_0001; end
        6: begin row.mat.m[0] = 32'hffff_ff00; row.mat.m[4] = 32'h0000_0100;
                 row.mat.m[8] = 32'h0000_0100; end
        default: for (int k = 0; k < 9; k++) row.mat.m[k] = $urandom;
      endcase
      row.typed = 1'b0; rows.push_back(row);
    end

    foreach (rows[n]) send_matrix(rows[n].mat, rows[n].typed, rows[n].inv);
    drain_results();

    // threshold extremes with random matrices
    for (int t = 0; t < 4; t++) begin
      case (t)
        0: write_threshold(17'd0);
        1: write_threshold(17'h10000);
        2: write_threshold(17'h1ffff);
        default: write_threshold(17'd3);
      endcase
      for (int n = 0; n < 6; n++) send_matrix(rand_matrix(n % 4), 1'b0, none);
      drain_results();
    end

    // back-pressure: receiver stalls while items keep coming
    hold_off_rx = 1'b1;
    for (int n = 0; n < 60; n++) send_matrix(rand_matrix(1), 1'b0, none);
    drain_results();

    // random part, threshold changed between phases
    for (int ph = 0; ph < 4; ph++) begin
      write_threshold(ph == 3 ? 17'd1 : 17'($urandom_range(0, 65536)));
      for (int n = 0; n < N_RANDOM / 4; n++) begin
        pick = $urandom_range(0, 9);
        a = rand_matrix(pick < 2 ? 0 : pick < 7 ? 1 : pick < 9 ? 2 : 3);
        send_matrix(a, 1'b0, none);
      end
      drain_results();
    end
    drain_done = 1'b1;
  end

  // receiver with random stalls and one long hold-off
  initial begin
    int wait_cyc;
    out_ready = 1'b0;
    @(negedge rst);
    forever begin
      if (hold_off_rx) begin
        out_ready <= 1'b0;
        repeat (300) @(posedge clk);
        hold_off_rx = 1'b0;
      end
      wait_cyc = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 16) : 0;
      if (wait_cyc != 0) begin
        out_ready <= 1'b0;
        repeat (wait_cyc) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
    end
  end

  // compare each result with the oldest expectation
  always @(posedge clk) begin
    inverse_t want;
    logic bad;
    if (!rst && out_valid && out_ready) begin
      if (expected_inv.size() == 0) begin
        fail_count++;
        if (mismatch_count < 10) $display("unexpected result item at cycle %0d", cycle_count);
        mismatch_count++;
      end else begin
        want = expected_inv.pop_front();
        bad = (sing_o !== want.sing) || (ovf_o !== want.ovf);
        for (int k = 0; k < 9; k++) if (ro[k] !== want.r[k]) bad = 1'b1;
        if (bad) begin
          fail_count++;
          if (mismatch_count < 10) begin
            $display("mismatch at cycle %0d: singular %0b/%0b overflow %0b/%0b",
                     cycle_count, want.sing, sing_o, want.ovf, ovf_o);
            for (int k = 0; k < 9; k++)
              $display("  r%0d%0d exp %h got %h", k / 3, k % 3, want.r[k], ro[k]);
          end
          mismatch_count++;
        end
      end
    end
  end

  // end of run and watchdog
  initial begin
    fail_count = 0;
    mismatch_count = 0;
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (drain_done) begin
        if (fail_count == 0 && expected_inv.size() == 0)
          $display("Verification passed");
        else
          $display("Verification failed");
        $finish;
      end else if (cycle_count > MAX_CYC) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

endmodule
